FILE: rtl/phr_pkg.sv
// Package: shared types and constants for the pixel hue rotator.
package phr_pkg;

  // Fixed-point formats
  localparam int HUE_FRAC_BITS = 8;
  localparam int SAT_FRAC_BITS = 12;
  localparam int HUE_W         = 17;                      // holds 0 .. 360*2^F - 1
  localparam int HUE_FULL      = 360 << HUE_FRAC_BITS;
  localparam int SECT_W        = 60 << HUE_FRAC_BITS;
  localparam int SECT_BITS     = 14;                      // holds 0 .. SECT_W
  localparam int HNUM_W        = 25;                      // 60*num*2^F, num < 6*256
  localparam int SNUM_W        = 20;                      // delta * 2^12
  localparam int QUO_W         = 17;                      // quotient bits of both dividers

  // floor(v/60) = (v*RECIP60) >> RECIP_SH, exact for v < 2^14
  localparam int RECIP60  = 17477;
  localparam int RECIP_SH = 20;

  localparam int QUEUE_DEPTH = 4;

  // Data that rides along with the hue division
  typedef struct packed {
    logic       bypass;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] sum;
    logic [7:0] span;
    logic [8:0] offset;
  } side_t;

  // One classified pixel word in the queue
  typedef struct packed {
    side_t             side;
    logic [7:0]        alpha;
    logic [HNUM_W-1:0] hue_num;
    logic [7:0]        hue_den;
    logic [SNUM_W-1:0] sat_num;
    logic [7:0]        sat_den;
  } entry_t;

endpackage

FILE: rtl/phr_front.sv
// Front end: classifies a pixel and prepares the hue and saturation divisions.
module phr_front (
  input  logic                [7:0] red,
  input  logic                [7:0] green,
  input  logic                [7:0] blue,
  input  logic                [7:0] alpha,
  input  logic                [8:0] hue_offset,
  output phr_pkg::entry_t           entry
);

  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  delta;
  logic [8:0]  sum;
  logic [7:0]  span;
  logic [8:0]  off;
  logic [10:0] num;
  logic        gray;

  // offset reduced modulo 360
  assign off = (hue_offset >= 9'd360) ? hue_offset - 9'd360 : hue_offset;

  // max, min, lightness terms
  always_comb begin
    mx = (red > green) ? red : green;
    if (blue > mx) mx = blue;
    mn = (red < green) ? red : green;
    if (blue < mn) mn = blue;
  end

  assign delta = mx - mn;
  assign sum   = {1'b0, mx} + {1'b0, mn};
  assign span  = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
  assign gray  = (delta == 8'd0);

  // hue numerator in units of delta per sector
  always_comb begin
    if (red == mx) begin
      if (green >= blue) num = 11'(green) - 11'(blue);
      else num = 11'(6) * 11'(delta) + 11'(green) - 11'(blue);
    end else if (green == mx) begin
      num = 11'(2) * 11'(delta) + 11'(blue) - 11'(red);
    end else begin
      num = 11'(4) * 11'(delta) + 11'(red) - 11'(green);
    end
  end

  // gray pixels divide zero by one
  always_comb begin
    entry.side.bypass = (off == 9'd0);
    entry.side.red    = red;
    entry.side.green  = green;
    entry.side.blue   = blue;
    entry.side.sum    = sum;
    entry.side.span   = span;
    entry.side.offset = off;
    entry.alpha       = alpha;
    entry.hue_num     = gray ? '0 :
                        (phr_pkg::HNUM_W'(num) * phr_pkg::HNUM_W'(60))
                          << phr_pkg::HUE_FRAC_BITS;
    entry.hue_den     = gray ? 8'd1 : delta;
    entry.sat_num     = gray ? '0 :
                        phr_pkg::SNUM_W'(delta) << phr_pkg::SAT_FRAC_BITS;
    entry.sat_den     = gray ? 8'd1 : span;
  end

endmodule

FILE: rtl/phr_queue.sv
// Short queue of classified pixel words between front and back.
module phr_queue #(
  parameter int DEPTH = phr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  phr_pkg::entry_t wr_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output phr_pkg::entry_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  phr_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_data   = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count over depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue popped while empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> count_r == '0) else $error("queue not empty after reset");

endmodule

FILE: rtl/phr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module phr_div #(
  parameter int NW = 25,
  parameter int DW = 8,
  parameter int QW = 17,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  localparam int XW = NW + QW + DW;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int J = QW - 1 - i;
    logic          pv;
    logic [NW-1:0] prem;
    logic [DW-1:0] pden;
    logic [QW-1:0] pquo;
    logic [SW-1:0] pside;
    logic [XW-1:0] dsh;
    logic          ge;
    logic          v_r;
    logic [NW-1:0] rem_r;
    logic [DW-1:0] den_r;
    logic [QW-1:0] quo_r;
    logic [SW-1:0] side_r;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = num;
      assign pden  = den;
      assign pquo  = '0;
      assign pside = side_in;
    end else begin : g_next
      assign pv    = g_stage[i-1].v_r;
      assign prem  = g_stage[i-1].rem_r;
      assign pden  = g_stage[i-1].den_r;
      assign pquo  = g_stage[i-1].quo_r;
      assign pside = g_stage[i-1].side_r;
    end

    // trial subtract of the divisor shifted to this bit
    assign dsh = XW'(pden) << J;
    assign ge  = (XW'(prem) >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? prem - NW'(dsh) : prem;
        den_r  <= pden;
        quo_r  <= pquo | (QW'(ge) << J);
        side_r <= pside;
      end
    end
  end

  assign out_valid = g_stage[QW-1].v_r;
  assign quo       = g_stage[QW-1].quo_r;
  assign side_out  = g_stage[QW-1].side_r;

endmodule

FILE: rtl/phr_back.sv
// Back end: divisions, hue rotation, HSL to RGB and the output register.
module phr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  phr_pkg::entry_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha
);

  localparam int HW = phr_pkg::HUE_W;
  localparam int QW = phr_pkg::QUO_W;
  localparam int FW = phr_pkg::SECT_BITS;
  localparam int SIDE_W = $bits(phr_pkg::side_t);

  typedef struct packed {
    phr_pkg::side_t side;
    logic [7:0]     alpha;
    logic [7:0]     chroma;
  } carry_t;

  logic adv;
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  // divisions
  logic              hv, sv;
  logic [QW-1:0]     hq, sq;
  logic [SIDE_W-1:0] hside;
  logic [7:0]        salpha;

  phr_div #(.NW(phr_pkg::HNUM_W), .DW(8), .QW(QW), .SW(SIDE_W)) u_hdiv (
    .clk, .rst_n, .en(adv), .in_valid(q_valid),
    .num(q_data.hue_num), .den(q_data.hue_den), .side_in(q_data.side),
    .out_valid(hv), .quo(hq), .side_out(hside)
  );

  phr_div #(.NW(phr_pkg::SNUM_W), .DW(8), .QW(QW), .SW(8)) u_sdiv (
    .clk, .rst_n, .en(adv), .in_valid(q_valid),
    .num(q_data.sat_num), .den(q_data.sat_den), .side_in(q_data.alpha),
    .out_valid(sv), .quo(sq), .side_out(salpha)
  );

  // stage A: rotate hue, chroma = d*s
  phr_pkg::side_t sd;
  logic [HW-1:0]  hcl;
  logic [HW:0]    hsum;
  logic [20:0]    cprod;
  logic           a_v_r;
  carry_t         a_c_r;
  logic [HW-1:0]  a_h_r;

  assign sd    = hside;
  assign hcl   = (hq >= QW'(phr_pkg::HUE_FULL)) ? HW'(phr_pkg::HUE_FULL - 1) : HW'(hq);
  assign hsum  = (HW+1)'(hcl) + ((HW+1)'(sd.offset) << phr_pkg::HUE_FRAC_BITS);
  assign cprod = 21'(sd.span) * 21'(sq[12:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= hv && sv;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_c_r.side   <= sd;
      a_c_r.alpha  <= salpha;
      a_c_r.chroma <= cprod[phr_pkg::SAT_FRAC_BITS +: 8];
      a_h_r        <= (hsum >= (HW+1)'(phr_pkg::HUE_FULL)) ?
                      HW'(hsum - (HW+1)'(phr_pkg::HUE_FULL)) : HW'(hsum);
    end
  end

  // stage B: sector and offset inside it
  logic [2:0]    sect;
  logic [HW-1:0] base;
  logic          b_v_r;
  carry_t        b_c_r;
  logic [2:0]    b_k_r;
  logic [FW-1:0] b_f_r;

  always_comb begin
    sect = 3'd0;
    base = '0;
    for (int i = 1; i < 6; i++) begin
      if (a_h_r >= HW'(i * phr_pkg::SECT_W)) begin
        sect = 3'(i);
        base = HW'(i * phr_pkg::SECT_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_c_r <= a_c_r;
      b_k_r <= sect;
      b_f_r <= FW'(a_h_r - base);
    end
  end

  // stage C: C*f or C*(W-f)
  logic [FW-1:0]   fsel;
  logic            c_v_r;
  carry_t          c_c_r;
  logic [2:0]      c_k_r;
  logic [FW+7:0]   c_p_r;

  assign fsel = b_k_r[0] ? FW'(phr_pkg::SECT_W) - b_f_r : b_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_c_r <= b_c_r;
      c_k_r <= b_k_r;
      c_p_r <= (FW+8)'(b_c_r.chroma) * (FW+8)'(fsel);
    end
  end

  // stage D: divide by W as shift then reciprocal of 60
  logic [FW-1:0] pv;
  logic [28:0]   xprod;
  logic          d_v_r;
  carry_t        d_c_r;
  logic [2:0]    d_k_r;
  logic [7:0]    d_x_r;

  assign pv    = c_p_r[phr_pkg::HUE_FRAC_BITS +: FW];
  assign xprod = 29'(pv) * 29'(phr_pkg::RECIP60);

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (adv) d_v_r <= c_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_c_r <= c_c_r;
      d_k_r <= c_k_r;
      d_x_r <= xprod[phr_pkg::RECIP_SH +: 8];
    end
  end

  // stage E: channels, sector order, output register
  logic [8:0] m2;
  logic [9:0] cm, xm;
  logic [7:0] cv, xv, mv;
  logic [7:0] ro, go, bo;

  assign m2 = d_c_r.side.sum - 9'(d_c_r.chroma);
  assign cm = 10'(d_c_r.side.sum) + 10'(d_c_r.chroma);
  assign xm = {1'b0, d_x_r, 1'b0} + 10'(m2);
  assign cv = cm[8:1];
  assign xv = xm[8:1];
  assign mv = m2[8:1];

  always_comb begin
    case (d_k_r)
      3'd0:    begin ro = cv; go = xv; bo = mv; end
      3'd1:    begin ro = xv; go = cv; bo = mv; end
      3'd2:    begin ro = mv; go = cv; bo = xv; end
      3'd3:    begin ro = mv; go = xv; bo = cv; end
      3'd4:    begin ro = xv; go = mv; bo = cv; end
      default: begin ro = cv; go = mv; bo = xv; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= d_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_alpha <= d_c_r.alpha;
      out_red   <= d_c_r.side.bypass ? d_c_r.side.red   : ro;
      out_green <= d_c_r.side.bypass ? d_c_r.side.green : go;
      out_blue  <= d_c_r.side.bypass ? d_c_r.side.blue  : bo;
    end
  end

  a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    hv == sv) else $error("divider pipelines out of step");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> adv) else $error("queue popped while back end stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(d_v_r) && $stable(a_v_r))
    else $error("pipeline moved while stalled");

endmodule

FILE: rtl/pixel_hue_rotator.sv
// Top level: HSL hue rotation of RGBA8888 pixel words.
// Path: the queue, then 17 divider stages, 4 conversion stages
//   and 1 output register; the dividers are fully pipelined.
// Throughput: one pixel word per cycle without output stalls, set by the dividers.
// A 4-word queue between classifier and pipeline decouples the two sides.
// Reset (rst_n, synchronous) empties queue and pipeline and clears hue_offset.
module pixel_hue_rotator #(
  parameter int QUEUE_DEPTH = phr_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data
);

  logic [8:0]      hue_offset_r;
  phr_pkg::entry_t fr_entry;
  phr_pkg::entry_t q_data;
  logic            q_full, q_valid, q_pop, push;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) hue_offset_r <= '0;
    else if (cfg_wr_en) hue_offset_r <= cfg_wr_data;
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  phr_front u_front (
    .red(in_red), .green(in_green), .blue(in_blue), .alpha(in_alpha),
    .hue_offset(hue_offset_r), .entry(fr_entry)
  );

  phr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .wr_data(fr_entry), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .rd_data(q_data)
  );

  phr_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop,
    .out_valid, .out_ready, .out_red, .out_green, .out_blue, .out_alpha
  );

endmodule

FILE: tb/sv/pixel_hue_rotator_tb.sv
// Testbench: random and directed pixel words through the hue rotator, checked against a predictor.
module pixel_hue_rotator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC      = phr_pkg::HUE_FRAC_BITS;
  localparam int LATENCY   = 22;
  localparam int CYCLE_CAP = 400000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       cfg_wr_en;
  logic [8:0] cfg_wr_data;

  pixel_t pending_pixels[$];
  pixel_t rotated_pixels[$];
  logic [8:0] offset_shadow;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;
  int mismatch_count;
  int cycle_count;
  int words_in;
  int words_out;

  pixel_hue_rotator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .in_alpha   (in_alpha),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // HSL round trip with the offset added to the hue
  function automatic pixel_t rotate_hue(pixel_t p, logic [8:0] offset_reg);
    longint unsigned r, g, b, off, full, wid, mx, mn, delta, sum, d, h, s;
    longint unsigned num, c, x, k, f, m2, cm, xm, mm;
    pixel_t q;
    r = 64'(p.red); g = 64'(p.green); b = 64'(p.blue);
    off = 64'(offset_reg) % 360;
    full = 64'(360) << FRAC;
    wid = 64'(60) << FRAC;
    h = 0; s = 0;
    q = p;
    if (off == 0) return q;
    mx = (r > g) ? r : g; if (b > mx) mx = b;
    mn = (r < g) ? r : g; if (b < mn) mn = b;
    delta = mx - mn;
    sum = mx + mn;
    d = (sum > 255) ? 510 - sum : sum;
    if (delta > 0) begin
      if (r == mx) num = (g >= b) ? (g - b) : (6 * delta + g - b);
      else if (g == mx) num = 2 * delta + b - r;
      else num = 4 * delta + r - g;
      h = ((60 * num) << FRAC) / delta;
      if (h >= full) h = full - 1;
      s = (delta << 12) / d;
    end
    h = (h + (off << FRAC)) % full;
    c = (d * s) >> 12;
    k = h / wid;
    f = h - k * wid;
    x = (k[0] == 1'b0) ? (c * f) / wid : (c * (wid - f)) / wid;
    m2 = sum - c;
    cm = (2 * c + m2) >> 1; if (cm > 255) cm = 255;
    xm = (2 * x + m2) >> 1; if (xm > 255) xm = 255;
    mm = m2 >> 1; if (mm > 255) mm = 255;
    case (k)
      0: begin q.red = 8'(cm); q.green = 8'(xm); q.blue = 8'(mm); end
      1: begin q.red = 8'(xm); q.green = 8'(cm); q.blue = 8'(mm); end
      2: begin q.red = 8'(mm); q.green = 8'(cm); q.blue = 8'(xm); end
      3: begin q.red = 8'(mm); q.green = 8'(xm); q.blue = 8'(cm); end
      4: begin q.red = 8'(xm); q.green = 8'(mm); q.blue = 8'(cm); end
      default: begin q.red = 8'(cm); q.green = 8'(mm); q.blue = 8'(xm); end
    endcase
    return q;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Driver: offers queued words, expectation recorded on accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rotated_pixels.push_back(rotate_hue({in_red, in_green, in_blue, in_alpha},
                                            offset_shadow));
        words_in <= words_in + 1;
      end
      if ((!in_valid || in_ready) && pending_pixels.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        pixel_t p;
        p = pending_pixels.pop_front();
        in_valid <= 1'b1;
        in_red   <= p.red;
        in_green <= p.green;
        in_blue  <= p.blue;
        in_alpha <= p.alpha;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, with an optional long hold-off
  always @(posedge clk) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_out <= words_out + 1;
      if (rotated_pixels.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10)
          $display("unexpected word %h", {out_red, out_green, out_blue, out_alpha});
      end else begin
        pixel_t e;
        e = rotated_pixels.pop_front();
        if (e.red !== out_red || e.green !== out_green || e.blue !== out_blue ||
            e.alpha !== out_alpha) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch rgba: expected %h %h %h %h, got %h %h %h %h",
                     e.red, e.green, e.blue, e.alpha, out_red, out_green, out_blue, out_alpha);
        end
      end
    end
  end

  task automatic drain();
    while (pending_pixels.size() > 0 || in_valid || rotated_pixels.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_offset(logic [8:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    offset_shadow <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = $urandom;
    case ($urandom_range(5))
      0: begin p.green = p.red; p.blue = p.red; end            // gray
      1: p.green = p.red;                                      // two channels tied
      2: begin p.red = 8'hff; p.blue = 8'h00; end             // full chroma
      default: ;
    endcase
    return p;
  endfunction

  task automatic load_random(int n);
    for (int i = 0; i < n; i++) pending_pixels.push_back(random_pixel());
  endtask

  initial begin
    logic [8:0] offsets[8];
    rst_n = 1'b0;
    in_valid = 1'b0; in_red = '0; in_green = '0; in_blue = '0; in_alpha = '0;
    out_ready = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
    offset_shadow = '0; send_idle_pct = 6; recv_idle_pct = 86; recv_hold_cycles = 0;
    mismatch_count = 0; cycle_count = 0; words_in = 0; words_out = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, grays, primaries, hue wrap cases, at reset offset then others
    offsets = '{9'd0, 9'd120, 9'd359, 9'd1, 9'd511, 9'd360, 9'd180, 9'd240};
    for (int o = 0; o < 3; o++) begin
      if (o > 0) write_offset(offsets[o]);
      pending_pixels.push_back('{8'h00, 8'h00, 8'h00, 8'h00});
      pending_pixels.push_back('{8'hff, 8'hff, 8'hff, 8'hff});
      pending_pixels.push_back('{8'h80, 8'h80, 8'h80, 8'h5a});
      pending_pixels.push_back('{8'hff, 8'h00, 8'h00, 8'ha5});
      pending_pixels.push_back('{8'h00, 8'hff, 8'h00, 8'h01});
      pending_pixels.push_back('{8'h00, 8'h00, 8'hff, 8'h7f});
      pending_pixels.push_back('{8'hff, 8'h00, 8'h01, 8'h80});
      pending_pixels.push_back('{8'h01, 8'h00, 8'h00, 8'hfe});
      drain();
    end

    // Random phases, each under its own offset, idling patterns rotate
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin send_idle_pct = 86; recv_idle_pct = 6; end
      if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_offset((ph < 5) ? offsets[ph + 3] : 9'($urandom_range(511)));
      if (ph == 7) begin
        // long receiver hold-off while the sender keeps offering
        recv_hold_cycles <= 200;
        send_idle_pct = 0;
      end
      load_random(150);
      drain();
    end

    $display("Covered %0d pixel words in, %0d out, across several hue offsets", words_in,
             words_out);
    $display("including gray, extreme and wrap cases, with stalls on both sides.");
    if (mismatch_count == 0 && rotated_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
